// ===== rtl/core/adnp_pkg.sv =====
// ----------------------------------------------------------------------------
// adnp_pkg
// Shared types and constants of the ASCII decimal number parser.
// ----------------------------------------------------------------------------
package adnp_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    localparam logic [30:0] INT_MAX     = 31'h7FFF_FFFF;
    localparam logic [14:0] WHOLE_MAX   = 15'd32767;
    localparam logic [31:0] FIXED_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] FRAC_MAX    = 32'hFFFF_FFFF;
    localparam logic [5:0]  LIMIT_RESET = 6'd20;

    // The place weight starts at one tenth in Q0.32 and is divided by ten,
    // rounded to nearest, after each fraction digit. It reaches zero at the
    // tenth fraction digit and stays there, so a saturating index suffices.
    localparam logic [3:0]  WT_LAST = 4'd9;

    typedef struct packed {
        logic [30:0] int_acc;
        logic [14:0] whole;
        logic [31:0] frac;
        logic [3:0]  wt_idx;
        logic        neg;
        logic        after_pt;
        logic [5:0]  chars;
    } t_parse_state;

    typedef struct packed {
        logic        fire;
        logic        timed_out;
        logic [30:0] int_value;
        logic [31:0] fixed_value;
    } t_result;

    localparam t_parse_state PARSE_CLEAR = '{default: '0};

    function automatic logic [31:0] place_weight(input logic [3:0] idx);
        logic [31:0] w;
        case (idx)
            4'd0:    w = 32'd429496730;
            4'd1:    w = 32'd42949673;
            4'd2:    w = 32'd4294967;
            4'd3:    w = 32'd429497;
            4'd4:    w = 32'd42950;
            4'd5:    w = 32'd4295;
            4'd6:    w = 32'd430;
            4'd7:    w = 32'd43;
            4'd8:    w = 32'd4;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/adnp_step.sv =====
// ----------------------------------------------------------------------------
// adnp_step
// Next-state and result logic for one character of the parser.
// ----------------------------------------------------------------------------
module adnp_step (
    input  adnp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_char,
    input  logic [5:0]             i_limit,
    output adnp_pkg::t_parse_state o_state,
    output adnp_pkg::t_result      o_result
);

    logic [3:0]  digit;
    logic [34:0] int_next;
    logic [18:0] whole_next;
    logic [31:0] weight;
    logic [35:0] frac_term;
    logic [36:0] frac_next;
    logic [5:0]  chars_next;
    logic [5:0]  limit_eff;
    logic [32:0] frac_rnd;
    logic [32:0] mag;
    logic [31:0] fixed_val;
    logic        term;

    assign digit      = i_char[3:0];
    assign int_next   = ({4'b0, i_state.int_acc} << 3) + ({4'b0, i_state.int_acc} << 1)
                        + {31'b0, digit};
    assign whole_next = ({4'b0, i_state.whole} << 3) + ({4'b0, i_state.whole} << 1)
                        + {15'b0, digit};
    assign weight     = adnp_pkg::place_weight(i_state.wt_idx);
    assign frac_term  = {32'b0, digit} * {4'b0, weight};
    assign frac_next  = {5'b0, i_state.frac} + {1'b0, frac_term};
    assign chars_next = i_state.chars + 6'd1;
    assign limit_eff  = (i_limit == 6'd0) ? 6'd1 : i_limit;

    // Magnitude is whole * 2^16 plus the fraction rounded to 16 bits.
    assign frac_rnd = {1'b0, i_state.frac} + 33'd32768;
    assign mag      = {2'b0, i_state.whole, 16'b0} + {16'b0, frac_rnd[32:16]};

    always_comb begin
        if (i_state.neg) begin
            fixed_val = ~mag[31:0] + 32'd1;
        end else if (mag[32] || mag[31]) begin
            fixed_val = adnp_pkg::FIXED_MAX;
        end else begin
            fixed_val = mag[31:0];
        end
    end

    always_comb begin
        o_state       = i_state;
        o_state.chars = chars_next;
        term          = 1'b0;
        o_result      = '0;

        case (i_char) inside
            [adnp_pkg::CHAR_ZERO:adnp_pkg::CHAR_NINE]: begin
                o_state.int_acc = (int_next > {4'b0, adnp_pkg::INT_MAX}) ?
                                  adnp_pkg::INT_MAX : int_next[30:0];
                if (i_state.after_pt) begin
                    o_state.frac = (|frac_next[36:32]) ? adnp_pkg::FRAC_MAX
                                                       : frac_next[31:0];
                    if (i_state.wt_idx != adnp_pkg::WT_LAST) begin
                        o_state.wt_idx = i_state.wt_idx + 4'd1;
                    end
                end else begin
                    o_state.whole = (whole_next > {4'b0, adnp_pkg::WHOLE_MAX}) ?
                                    adnp_pkg::WHOLE_MAX : whole_next[14:0];
                end
            end
            adnp_pkg::CHAR_DOT: begin
                o_state.after_pt = 1'b1;
            end
            adnp_pkg::CHAR_MINUS: begin
                o_state.neg = 1'b1;
            end
            adnp_pkg::CHAR_COMMA, adnp_pkg::CHAR_SEMI: begin
                term = 1'b1;
            end
            default: begin
            end
        endcase

        if (term) begin
            o_result.fire        = 1'b1;
            o_result.int_value   = i_state.int_acc;
            o_result.fixed_value = fixed_val;
            o_state              = adnp_pkg::PARSE_CLEAR;
        end else if (chars_next >= limit_eff) begin
            o_result.fire      = 1'b1;
            o_result.timed_out = 1'b1;
            o_state            = adnp_pkg::PARSE_CLEAR;
        end
    end

endmodule

// ===== rtl/core/ascii_decimal_number_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser
// Parses comma or semicolon terminated decimal numbers from a character
// stream into a saturating integer and a signed Q15.16 value.
// ----------------------------------------------------------------------------
//  channel   direction  word contents
//  s_axis    in         tdata[7:0] char_code
//  m_axis    out        tdata[30:0] int_value, [62:31] fixed_value; tuser timed_out
//  cfg       in         i_cfg_data[5:0] char_limit
//
// One character per cycle is sustained. A character is held in the input
// register and parsed from there into the result register, which then holds
// the result word of its terminating character until it is taken.
// The only loop is the parser state update. While a result waits
// in the output register the pipeline stalls and s_axis_tready drops once the
// input register is full. Reset is synchronous; char_limit resets to 20.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [30:0] int_value, [62:31] fixed_value, [63] zero
    output logic [0:0]  m_axis_tuser,   // [0] timed_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    logic                   r_in_vld;
    logic [7:0]             r_in_char;
    logic                   r_out_vld;
    logic [30:0]            r_int_value;
    logic [31:0]            r_fixed_value;
    logic                   r_timed_out;
    logic [5:0]             r_limit;
    adnp_pkg::t_parse_state r_state;
    adnp_pkg::t_parse_state n_state;
    adnp_pkg::t_result      step_res;
    logic                   advance;
    logic                   step_en;

    adnp_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .i_limit  (r_limit),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign advance       = !r_out_vld || m_axis_tready;
    assign step_en       = r_in_vld && advance;
    assign s_axis_tready = !r_in_vld || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= adnp_pkg::PARSE_CLEAR;
            r_limit   <= adnp_pkg::LIMIT_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (step_en) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_vld <= step_en && step_res.fire;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
        end
        if (step_en && step_res.fire) begin
            r_int_value   <= step_res.int_value;
            r_fixed_value <= step_res.fixed_value;
            r_timed_out   <= step_res.timed_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_fixed_value, r_int_value};
    assign m_axis_tuser  = r_timed_out;

endmodule

// ===== rtl/core/adnp_checker.sv =====
// ----------------------------------------------------------------------------
// adnp_checker
// Port-level checks of the ASCII decimal number parser, bound to the top.
// ----------------------------------------------------------------------------
module adnp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A timeout word carries zero in both views.
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("timeout word with nonzero data");

    // The input side only stalls behind a result that is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

    // The pad bit above the fixed-point view stays clear.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[63])
        else $error("pad bit set in result word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind ascii_decimal_number_parser adnp_checker u_adnp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/ascii_decimal_number_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser_tb
// Self-checking bench for the ASCII decimal number parser. Characters are
// streamed in with random source gaps and sink stalls. Every accepted
// character goes through a local parser model, and each output word is
// checked against the oldest predicted number. The character limit is
// changed between phases, including the extremes and the out-of-range zero.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser_tb;

    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [31:0] ONE_TENTH   = 32'h1999_999A;

    typedef struct packed {
        logic [30:0] int_value;
        logic [31:0] fixed_value;
        logic        timed_out;
    } t_number;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] char_code
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [30:0] int_value, [62:31] fixed_value, [63] zero
    logic [0:0]  m_axis_tuser;         // [0] timed_out
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data = '0;

    logic [7:0]  char_backlog [$];
    t_number     parsed_due [$];
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    // Local copy of the parser state and the limit register.
    logic [5:0]  limit_reg = adnp_pkg::LIMIT_RESET;
    logic [30:0] acc_int = '0;
    logic [14:0] acc_whole = '0;
    logic [31:0] frac_sum = '0;
    logic [31:0] weight = ONE_TENTH;
    logic        neg_seen = 1'b0;
    logic        point_seen = 1'b0;
    logic [5:0]  n_chars = '0;

    ascii_decimal_number_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_number();
        acc_int    = '0;
        acc_whole  = '0;
        frac_sum   = '0;
        weight     = ONE_TENTH;
        neg_seen   = 1'b0;
        point_seen = 1'b0;
        n_chars    = '0;
    endfunction

    // Advances the parser by one character; returns 1 when a number is given.
    function automatic bit parse_char(input logic [7:0] c, output t_number r);
        logic [63:0] wide;
        logic [63:0] mag;
        logic [3:0]  d;
        logic [5:0]  lim;
        lim     = (limit_reg == 6'd0) ? 6'd1 : limit_reg;
        n_chars = n_chars + 6'd1;
        r       = '0;
        if (c >= adnp_pkg::CHAR_ZERO && c <= adnp_pkg::CHAR_NINE) begin
            d    = 4'(c - adnp_pkg::CHAR_ZERO);
            wide = 64'(acc_int) * 64'd10 + 64'(d);
            acc_int = (wide > 64'(adnp_pkg::INT_MAX)) ? adnp_pkg::INT_MAX : wide[30:0];
            if (point_seen) begin
                wide     = 64'(frac_sum) + 64'(d) * 64'(weight);
                frac_sum = (wide > 64'(adnp_pkg::FRAC_MAX)) ? adnp_pkg::FRAC_MAX
                                                             : wide[31:0];
                wide     = (64'(weight) + 64'd5) / 64'd10;
                weight   = wide[31:0];
            end else begin
                wide      = 64'(acc_whole) * 64'd10 + 64'(d);
                acc_whole = (wide > 64'(adnp_pkg::WHOLE_MAX)) ? adnp_pkg::WHOLE_MAX
                                                               : wide[14:0];
            end
        end else if (c == adnp_pkg::CHAR_DOT) begin
            point_seen = 1'b1;
        end else if (c == adnp_pkg::CHAR_MINUS) begin
            neg_seen = 1'b1;
        end else if (c == adnp_pkg::CHAR_COMMA || c == adnp_pkg::CHAR_SEMI) begin
            mag = (64'(acc_whole) << 16) + ((64'(frac_sum) + 64'd32768) >> 16);
            r.int_value = acc_int;
            if (neg_seen) begin
                wide = 64'd0 - mag;
                r.fixed_value = wide[31:0];
            end else begin
                r.fixed_value = (mag > 64'(adnp_pkg::FIXED_MAX)) ? adnp_pkg::FIXED_MAX
                                                                  : mag[31:0];
            end
            clear_number();
            return 1'b1;
        end
        if (n_chars >= lim) begin
            r.timed_out = 1'b1;
            clear_number();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] random_digit(input bit nines);
        return nines ? adnp_pkg::CHAR_NINE : adnp_pkg::CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] parser_symbol();
        case ($urandom_range(5))
            0:       return adnp_pkg::CHAR_DOT;
            1:       return adnp_pkg::CHAR_MINUS;
            2:       return adnp_pkg::CHAR_COMMA;
            3:       return adnp_pkg::CHAR_SEMI;
            4:       return 8'($urandom_range(255));
            default: return random_digit(1'b0);
        endcase
    endfunction

    // Mostly well-formed numbers with random content, plus noise and
    // unstructured runs of parser symbols.
    task automatic queue_random_text(input int target, input int max_digits);
        int  roll;
        int  n;
        bit  nines;
        while (char_backlog.size() < target) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                n = $urandom_range(1, 4);
                repeat (n) char_backlog.push_back(8'($urandom_range(255)));
            end else if (roll < 20) begin
                n = $urandom_range(1, 12);
                repeat (n) char_backlog.push_back(parser_symbol());
            end else begin
                nines = ($urandom_range(3) == 0);
                if ($urandom_range(2) == 0)
                    char_backlog.push_back(adnp_pkg::CHAR_MINUS);
                n = ($urandom_range(5) == 0) ? $urandom_range(6, max_digits)
                                             : $urandom_range(0, 5);
                repeat (n) char_backlog.push_back(random_digit(nines));
                if ($urandom_range(3) != 0) begin
                    char_backlog.push_back(adnp_pkg::CHAR_DOT);
                    n = ($urandom_range(4) == 0) ? $urandom_range(6, max_digits)
                                                 : $urandom_range(0, 5);
                    repeat (n) char_backlog.push_back(random_digit(nines));
                end
                if ($urandom_range(9) == 0)
                    char_backlog.push_back(parser_symbol());
                char_backlog.push_back($urandom_range(1) ? adnp_pkg::CHAR_COMMA
                                                         : adnp_pkg::CHAR_SEMI);
            end
        end
    endtask

    task automatic wait_idle();
        while (char_backlog.size() != 0 || s_axis_tvalid || parsed_due.size() != 0)
            @(posedge i_clk);
        // A trailing character that gives no result may still be in flight.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [5:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limit_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Source side: one character word per handshake.
    always @(posedge i_clk) begin
        t_number outcome;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (parse_char(s_axis_tdata, outcome))
                    parsed_due.push_back(outcome);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (char_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= char_backlog.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: compare each result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_number seen;
        t_number want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.int_value   = m_axis_tdata[30:0];
                seen.fixed_value = m_axis_tdata[62:31];
                seen.timed_out   = m_axis_tuser[0];
                if (parsed_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected word, expected none, actual %h", $time, seen);
                end else begin
                    want = parsed_due.pop_front();
                    if (seen.int_value !== want.int_value) begin
                        error_count++;
                        $display("%0t: int_value expected %0d actual %0d",
                                 $time, want.int_value, seen.int_value);
                    end
                    if (seen.fixed_value !== want.fixed_value) begin
                        error_count++;
                        $display("%0t: fixed_value expected %h actual %h",
                                 $time, want.fixed_value, seen.fixed_value);
                    end
                    if (seen.timed_out !== want.timed_out) begin
                        error_count++;
                        $display("%0t: timed_out expected %b actual %b",
                                 $time, want.timed_out, seen.timed_out);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        string       text;
        logic [5:0]  lim;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed text at the reset limit: repeated signs and dots, ignored
        // codes, both terminators, every digit and an empty number.
        text = "-34.25-.7;";
        for (int k = 0; k < text.len(); k++) char_backlog.push_back(text[k]);
        char_backlog.push_back(8'h00);
        char_backlog.push_back(8'hFF);
        text = "10,98.6,;";
        for (int k = 0; k < text.len(); k++) char_backlog.push_back(text[k]);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       lim = 6'd63;
                1:       lim = 6'd1;
                2:       lim = 6'd0;
                3:       lim = adnp_pkg::LIMIT_RESET;
                default: lim = 6'($urandom_range(2, 40));
            endcase
            write_limit(lim);
            case (ph % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 71; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 71; end
                default: begin src_idle_pct = 7;  sink_stall_pct = 7;  end
            endcase
            queue_random_text(165, (lim >= 6'd40) ? 28 : 14);
            wait_idle();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
